// ===== rtl/tmsd_pkg.sv =====
package tmsd_pkg;

    // Display geometry and animation length.
    localparam int DIGIT_COUNT = 4;
    localparam int FRAME_COUNT = 6;
    localparam int FRAME_W     = 3;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_TEMPO_FLOOR    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEMPO_CEILING  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEMPO_DEADBAND = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ANIM_PERIOD    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MSG_HOLD       = 3'd4;

    // Register reset values.
    localparam logic [9:0]  RST_TEMPO_FLOOR    = 10'd20;
    localparam logic [9:0]  RST_TEMPO_CEILING  = 10'd400;
    localparam logic [7:0]  RST_TEMPO_DEADBAND = 8'd2;
    localparam logic [15:0] RST_ANIM_PERIOD    = 16'd100;
    localparam logic [15:0] RST_MSG_HOLD       = 16'd1000;

    // Fixed segment patterns: bit0 top through bit6 middle, bit7 point.
    localparam logic [7:0] SEG_BLANK  = 8'h00;
    localparam logic [7:0] SEG_LOW_T  = 8'h78;
    localparam logic [7:0] SEG_POINT  = 8'h80;
    localparam logic [7:0] SEG_ZERO_P = 8'hBF;
    localparam logic [7:0] SEG_N_P    = 8'hD4;
    localparam logic [7:0] SEG_S      = 8'h6D;
    localparam logic [7:0] SEG_B      = 8'h7C;
    localparam logic [7:0] SEG_Y      = 8'h6E;

    // Event codes carried on the input side.
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_TEMPO       = 3'd1,
        CMD_CLOCK_START = 3'd2,
        CMD_IDLE_START  = 3'd3,
        CMD_MIDI        = 3'd4,
        CMD_STANDBY     = 3'd5
    } cmd_t;

    typedef logic [7:0] seg_t;
    typedef seg_t [DIGIT_COUNT-1:0] digits_t;

    // Configuration register set.
    typedef struct packed {
        logic [9:0]  tempo_floor;
        logic [9:0]  tempo_ceiling;
        logic [7:0]  tempo_deadband;
        logic [15:0] anim_period;
        logic [15:0] msg_hold;
    } cfg_t;

    // Display state.
    typedef struct packed {
        digits_t              digits;
        logic                 idle;
        logic                 msg;
        logic [9:0]           shown_tempo;
        logic [FRAME_W-1:0]   frame;
        logic [15:0]          anim_elapsed;
        logic [15:0]          msg_elapsed;
    } disp_state_t;

    // Formatted tempo and whether it passes the deadband.
    typedef struct packed {
        logic       update;
        logic [9:0] value;
        digits_t    digits;
    } tempo_fmt_t;

    // Hex digit to segment pattern.
    function automatic seg_t hex_seg(input logic [3:0] d);
        seg_t s;
        case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            default: s = 8'h71;
        endcase
        return s;
    endfunction

    // Rotating segment for one animation frame.
    function automatic seg_t spin_seg(input logic [FRAME_W-1:0] f);
        seg_t s;
        case (f)
            3'd0: s = 8'h01;
            3'd1: s = 8'h02;
            3'd2: s = 8'h04;
            3'd3: s = 8'h08;
            3'd4: s = 8'h10;
            3'd5: s = 8'h20;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/tmsd_cfg_regs.sv =====
module tmsd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tmsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tmsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tmsd_pkg::cfg_t                    cfg
);
    import tmsd_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode; addresses past the last register are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TEMPO_FLOOR:    cfg_next.tempo_floor    = pwdata[9:0];
                REG_TEMPO_CEILING:  cfg_next.tempo_ceiling  = pwdata[9:0];
                REG_TEMPO_DEADBAND: cfg_next.tempo_deadband = pwdata[7:0];
                REG_ANIM_PERIOD:    cfg_next.anim_period    = pwdata[15:0];
                REG_MSG_HOLD:       cfg_next.msg_hold       = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tempo_floor    <= RST_TEMPO_FLOOR;
            cfg_reg.tempo_ceiling  <= RST_TEMPO_CEILING;
            cfg_reg.tempo_deadband <= RST_TEMPO_DEADBAND;
            cfg_reg.anim_period    <= RST_ANIM_PERIOD;
            cfg_reg.msg_hold       <= RST_MSG_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_idx)
            REG_TEMPO_FLOOR:    prdata = {22'd0, cfg_reg.tempo_floor};
            REG_TEMPO_CEILING:  prdata = {22'd0, cfg_reg.tempo_ceiling};
            REG_TEMPO_DEADBAND: prdata = {24'd0, cfg_reg.tempo_deadband};
            REG_ANIM_PERIOD:    prdata = {16'd0, cfg_reg.anim_period};
            REG_MSG_HOLD:       prdata = {16'd0, cfg_reg.msg_hold};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tmsd_tempo_fmt.sv =====
module tmsd_tempo_fmt (
    input  logic [15:0]          tempo_value,
    input  logic [9:0]           shown_tempo,
    input  tmsd_pkg::cfg_t       cfg,
    output tmsd_pkg::tempo_fmt_t fmt
);
    import tmsd_pkg::*;

    logic [9:0]  clamped;
    logic [9:0]  diff;
    logic [15:0] prod_hund;
    logic [3:0]  quot_hund;
    logic [10:0] hund_part;
    logic [10:0] rem_full;
    logic [6:0]  rem_hund;
    logic [14:0] prod_tens;
    logic [3:0]  tens;
    logic [6:0]  tens_part;
    logic [6:0]  ones_full;
    logic [3:0]  ones;
    logic [3:0]  hund;

    // Clamp; if floor > ceiling, only values below the floor get it.
    always_comb
    begin
        if (tempo_value < {6'd0, cfg.tempo_floor})
        begin
            clamped = cfg.tempo_floor;
        end
        else if (tempo_value > {6'd0, cfg.tempo_ceiling})
        begin
            clamped = cfg.tempo_ceiling;
        end
        else
        begin
            clamped = tempo_value[9:0];
        end
    end

    // Distance from the value on display, against the deadband.
    assign diff = (clamped > shown_tempo) ? (clamped - shown_tempo) : (shown_tempo - clamped);

    // Divide by 100 through the reciprocal 41/4096, exact below 1024.
    assign prod_hund = 16'(clamped) * 16'd41;
    assign quot_hund = prod_hund[15:12];
    assign hund_part = 11'(quot_hund) * 11'd100;
    assign rem_full  = {1'b0, clamped} - hund_part;
    assign rem_hund  = rem_full[6:0];

    // Divide the remainder by 10 through 205/2048, exact below 1029.
    assign prod_tens = 15'(rem_hund) * 15'd205;
    assign tens      = prod_tens[14:11];
    assign tens_part = 7'(tens) * 7'd10;
    assign ones_full = rem_hund - tens_part;
    assign ones      = ones_full[3:0];

    // A quotient of ten wraps to zero, which shows blank.
    assign hund = (quot_hund == 4'd10) ? 4'd0 : quot_hund;

    always_comb
    begin
        fmt.update    = diff > {2'd0, cfg.tempo_deadband};
        fmt.value     = clamped;
        fmt.digits[0] = SEG_LOW_T;
        fmt.digits[1] = (hund == 4'd0) ? SEG_BLANK : hex_seg(hund);
        fmt.digits[2] = hex_seg(tens);
        fmt.digits[3] = hex_seg(ones) | SEG_POINT;
    end

endmodule

// ===== rtl/tmsd_engine.sv =====
module tmsd_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  tmsd_pkg::cmd_t          cmd,
    input  logic [15:0]             tempo_value,
    input  logic [7:0]              midi_data,
    input  logic [3:0]              midi_channel,
    input  tmsd_pkg::cfg_t          cfg,
    output tmsd_pkg::disp_state_t   state_next
);
    import tmsd_pkg::*;

    disp_state_t        st_reg;
    disp_state_t        st_next;
    tempo_fmt_t         fmt;
    logic [15:0]        anim_inc;
    logic [15:0]        msg_inc;
    logic               msg_kept;
    logic [FRAME_W-1:0] frame_adv;
    digits_t            spin_digits;

    tmsd_tempo_fmt u_tempo_fmt (
        .tempo_value (tempo_value),
        .shown_tempo (st_reg.shown_tempo),
        .cfg         (cfg),
        .fmt         (fmt)
    );

    // Saturating millisecond counters.
    assign anim_inc = (st_reg.anim_elapsed != 16'hFFFF) ? (st_reg.anim_elapsed + 16'd1)
                                                        : st_reg.anim_elapsed;
    assign msg_inc  = (st_reg.msg && (st_reg.msg_elapsed != 16'hFFFF))
                      ? (st_reg.msg_elapsed + 16'd1) : st_reg.msg_elapsed;
    assign msg_kept = st_reg.msg && (msg_inc < cfg.msg_hold);

    // Each digit runs one frame ahead of its left neighbor.
    for (genvar g = 0; g < DIGIT_COUNT; g++)
    begin : g_spin
        logic [3:0] spin_sum;
        logic [3:0] spin_idx;
        assign spin_sum       = 4'(st_reg.frame) + 4'(g);
        assign spin_idx       = (spin_sum >= 4'(FRAME_COUNT)) ? (spin_sum - 4'(FRAME_COUNT))
                                                              : spin_sum;
        assign spin_digits[g] = spin_seg(spin_idx[FRAME_W-1:0]);
    end

    assign frame_adv = (st_reg.frame == FRAME_W'(FRAME_COUNT - 1)) ? '0
                                                                   : (st_reg.frame + 1'b1);

    // Event handling for one beat.
    always_comb
    begin
        st_next = st_reg;
        if (step)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    st_next.anim_elapsed = anim_inc;
                    st_next.msg_elapsed  = msg_inc;
                    if (st_reg.idle && (anim_inc >= cfg.anim_period))
                    begin
                        st_next.anim_elapsed = '0;
                        st_next.msg          = msg_kept;
                        if (!msg_kept)
                        begin
                            st_next.digits = spin_digits;
                            st_next.frame  = frame_adv;
                        end
                    end
                end
                CMD_TEMPO:
                begin
                    if (fmt.update)
                    begin
                        st_next.shown_tempo = fmt.value;
                        st_next.digits      = fmt.digits;
                    end
                end
                CMD_CLOCK_START:
                begin
                    st_next.idle        = 1'b0;
                    st_next.msg         = 1'b0;
                    st_next.shown_tempo = '0;
                    st_next.digits[0]   = SEG_LOW_T;
                    st_next.digits[1]   = SEG_BLANK;
                    st_next.digits[2]   = SEG_BLANK;
                    st_next.digits[3]   = SEG_ZERO_P;
                end
                CMD_IDLE_START:
                begin
                    st_next.idle         = 1'b1;
                    st_next.frame        = '0;
                    st_next.anim_elapsed = '0;
                    st_next.shown_tempo  = '0;
                end
                CMD_MIDI:
                begin
                    if (st_reg.idle)
                    begin
                        st_next.msg         = 1'b1;
                        st_next.msg_elapsed = '0;
                        st_next.digits[0]   = hex_seg(midi_channel);
                        st_next.digits[1]   = SEG_N_P;
                        st_next.digits[2]   = hex_seg(midi_data[7:4]);
                        st_next.digits[3]   = hex_seg(midi_data[3:0]);
                    end
                end
                CMD_STANDBY:
                begin
                    st_next.digits[0] = SEG_S;
                    st_next.digits[1] = SEG_LOW_T;
                    st_next.digits[2] = SEG_B;
                    st_next.digits[3] = SEG_Y;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign state_next = st_next;

endmodule

// ===== rtl/tempo_and_midi_segment_display_core.sv =====
// Four-digit 7-segment display controller for a tempo and MIDI monitor. Each
// input beat carries one event (millisecond tick, tempo, clock start, idle
// start, MIDI event or standby) in s_tuser and returns exactly one output beat
// with the four segment patterns and the idle and message flags as they stand
// after that event. The block takes a new beat every clock cycle unless the
// output side stalls it; an accepted beat waits in the input register while
// the single-pass state update computes the value that loads the result
// register. Backpressure on the output side stalls the input side only once
// both registers are full. The user must see that configuration registers are
// written through the APB port only while no beat is in flight; the block
// itself does not enforce this.
module tempo_and_midi_segment_display_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // tempo_value, midi_data, midi_channel, pad
    input  logic [2:0]                        s_tuser,  // command
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // segments_0..3, idle_active, message_showing
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tmsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tmsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tmsd_pkg::*;

    cfg_t        cfg;
    disp_state_t state_next;

    logic        in_valid_reg;
    logic        in_valid_next;
    cmd_t        in_cmd_reg;
    logic [15:0] in_tempo_reg;
    logic [7:0]  in_data_reg;
    logic [3:0]  in_chan_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    digits_t     out_digits_reg;
    logic        out_idle_reg;
    logic        out_msg_reg;

    logic        s_fire;
    logic        advance;

    tmsd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the input register moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_tempo_reg <= s_tdata[15:0];
            in_data_reg  <= s_tdata[23:16];
            in_chan_reg  <= s_tdata[27:24];
        end
    end

    tmsd_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .cmd          (in_cmd_reg),
        .tempo_value  (in_tempo_reg),
        .midi_data    (in_data_reg),
        .midi_channel (in_chan_reg),
        .cfg          (cfg),
        .state_next   (state_next)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_digits_reg <= state_next.digits;
            out_idle_reg   <= state_next.idle;
            out_msg_reg    <= state_next.msg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_msg_reg, out_idle_reg, out_digits_reg};

endmodule

// ===== rtl/tmsd_checker.sv =====
module tmsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled output beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // The input side only stalls when a result is waiting and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A MIDI message is only held while idle mode is on.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[33] || m_tdata[32])
        else $error("message showing outside idle mode");

    // The pad bits of an output beat stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:34] == 6'd0)
        else $error("output pad bits set");

endmodule

bind tempo_and_midi_segment_display_core tmsd_checker u_tmsd_checker (.*);

// ===== tb/tempo_and_midi_segment_display_core_test.sv =====
`timescale 1ns / 1ps

module tempo_and_midi_segment_display_core_test;

    import tmsd_pkg::*;

    // Longest run of cycles with no handshake before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    // Command codes the block does not define; they must leave the display alone.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Hex digit glyphs, bit0 top through bit6 middle.
    localparam seg_t HEX_GLYPH [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    // One output beat as it sits in the low bits of m_tdata.
    typedef struct packed {
        logic    msg;
        logic    idle;
        digits_t seg;
    } display_t;

    // Tracks the display state and holds the display beats still owed by the block.
    class display_scoreboard;
        logic [9:0]  floor_q;
        logic [9:0]  ceil_q;
        logic [7:0]  deadband_q;
        logic [15:0] period_q;
        logic [15:0] hold_q;

        digits_t     digits;
        logic        idle_on;
        logic        msg_on;
        logic [9:0]  tempo_shown;
        int unsigned frame;
        logic [15:0] anim_ms;
        logic [15:0] msg_ms;

        display_t    pending_displays[$];
        int unsigned mismatches;
        int unsigned displays_checked;

        function new();
            floor_q          = RST_TEMPO_FLOOR;
            ceil_q           = RST_TEMPO_CEILING;
            deadband_q       = RST_TEMPO_DEADBAND;
            period_q         = RST_ANIM_PERIOD;
            hold_q           = RST_MSG_HOLD;
            digits           = '0;
            idle_on          = 1'b0;
            msg_on           = 1'b0;
            tempo_shown      = '0;
            frame            = 0;
            anim_ms          = '0;
            msg_ms           = '0;
            mismatches       = 0;
            displays_checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_TEMPO_FLOOR:    floor_q = value[9:0];
                REG_TEMPO_CEILING:  ceil_q = value[9:0];
                REG_TEMPO_DEADBAND: deadband_q = value[7:0];
                REG_ANIM_PERIOD:    period_q = value[15:0];
                REG_MSG_HOLD:       hold_q = value[15:0];
                default: ;
            endcase
        endfunction

        function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s at display %0d: expected %0h, got %0h",
                         what, displays_checked, want, got);
        endfunction

        // Apply one accepted input beat and queue the display it must produce.
        function void note_event(logic [2:0] cmd, logic [15:0] tempo, logic [7:0] data,
                                 logic [3:0] chan);
            int unsigned v;
            int unsigned diff;
            int unsigned h;
            int          i;
            display_t    d;
            case (cmd)
                CMD_TICK:
                begin
                    if (anim_ms != 16'hFFFF) anim_ms++;
                    if (msg_on && msg_ms != 16'hFFFF) msg_ms++;
                    if (idle_on && anim_ms >= period_q)
                    begin
                        anim_ms = '0;
                        if (msg_on && msg_ms >= hold_q) msg_on = 1'b0;
                        // Each digit runs one frame ahead of its left neighbor.
                        if (!msg_on)
                        begin
                            for (i = 0; i < DIGIT_COUNT; i++)
                                digits[i] = 8'h01 << ((frame + i) % FRAME_COUNT);
                            frame = (frame + 1) % FRAME_COUNT;
                        end
                    end
                end
                CMD_TEMPO:
                begin
                    v = tempo;
                    if (v < floor_q) v = floor_q;
                    else if (v > ceil_q) v = ceil_q;
                    diff = (v > tempo_shown) ? v - tempo_shown : tempo_shown - v;
                    if (diff > deadband_q)
                    begin
                        tempo_shown = v[9:0];
                        h = (v / 100) % 10;
                        digits[0] = SEG_LOW_T;
                        digits[1] = (h > 0) ? HEX_GLYPH[h] : SEG_BLANK;
                        digits[2] = HEX_GLYPH[(v / 10) % 10];
                        digits[3] = HEX_GLYPH[v % 10] | SEG_POINT;
                    end
                end
                CMD_CLOCK_START:
                begin
                    idle_on     = 1'b0;
                    msg_on      = 1'b0;
                    tempo_shown = '0;
                    digits[0]   = SEG_LOW_T;
                    digits[1]   = SEG_BLANK;
                    digits[2]   = SEG_BLANK;
                    digits[3]   = SEG_ZERO_P;
                end
                CMD_IDLE_START:
                begin
                    idle_on     = 1'b1;
                    frame       = 0;
                    anim_ms     = '0;
                    tempo_shown = '0;
                end
                CMD_MIDI:
                begin
                    // Events outside idle mode are dropped.
                    if (idle_on)
                    begin
                        msg_on    = 1'b1;
                        msg_ms    = '0;
                        digits[0] = HEX_GLYPH[chan];
                        digits[1] = SEG_N_P;
                        digits[2] = HEX_GLYPH[data[7:4]];
                        digits[3] = HEX_GLYPH[data[3:0]];
                    end
                end
                CMD_STANDBY:
                begin
                    digits[0] = SEG_S;
                    digits[1] = SEG_LOW_T;
                    digits[2] = SEG_B;
                    digits[3] = SEG_Y;
                end
                default: ;
            endcase
            d.seg  = digits;
            d.idle = idle_on;
            d.msg  = msg_on;
            pending_displays.push_back(d);
        endfunction

        // Compare one output beat against the oldest pending display, field by field.
        function void check_display(logic [39:0] beat);
            display_t got;
            display_t want;
            int       i;
            got = beat[33:0];
            if (pending_displays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected display beat %h with nothing pending", beat);
                return;
            end
            want = pending_displays.pop_front();
            displays_checked++;
            for (i = 0; i < DIGIT_COUNT; i++)
                if (got.seg[i] !== want.seg[i])
                    report_mismatch($sformatf("segments_%0d", i), 32'(want.seg[i]),
                                    32'(got.seg[i]));
            if (got.idle !== want.idle)
                report_mismatch("idle_active", 32'(want.idle), 32'(got.idle));
            if (got.msg !== want.msg)
                report_mismatch("message_showing", 32'(want.msg), 32'(got.msg));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // tempo_value, midi_data, midi_channel, zero pad
    logic [2:0]            s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // segments_0..3, idle_active, message_showing
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    display_scoreboard sb;
    bit                quiet;
    int unsigned       events_sent;
    int unsigned       settings_used;
    int unsigned       idle_cycles;

    tempo_and_midi_segment_display_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle length between beats: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side backpressure.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                m_tready <= 1'b1;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // Every accepted output beat is checked.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_display(m_tdata);
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d displays outstanding",
                         idle_cycles, sb.pending_displays.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one event beat and hold it until accepted, then maybe idle.
    task automatic send_event(logic [2:0] cmd, logic [15:0] tempo, logic [7:0] data,
                              logic [3:0] chan);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'h0, chan, data, tempo};
        do @(posedge clk); while (!s_tready);
        sb.note_event(cmd, tempo, data, chan);
        events_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Write one register, then read it back.
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) sb.report_mismatch($sformatf("readback of register %0d", idx),
                                                 value, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending and wait until the block has delivered everything it owes.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_displays.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [9:0] lo, logic [9:0] hi, logic [7:0] band,
                             logic [15:0] period, logic [15:0] hold);
        settle();
        write_register(REG_TEMPO_FLOOR, 32'(lo));
        write_register(REG_TEMPO_CEILING, 32'(hi));
        write_register(REG_TEMPO_DEADBAND, 32'(band));
        write_register(REG_ANIM_PERIOD, 32'(period));
        write_register(REG_MSG_HOLD, 32'(hold));
        settings_used++;
    endtask

    // Random event mix weighted toward ticks and idle-mode traffic.
    task automatic random_phase(int count);
        int          r;
        int          near;
        logic [2:0]  cmd;
        logic [15:0] tv;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 48) cmd = CMD_TICK;
            else if (r < 63) cmd = CMD_TEMPO;
            else if (r < 76) cmd = CMD_MIDI;
            else if (r < 83) cmd = CMD_IDLE_START;
            else if (r < 87) cmd = CMD_CLOCK_START;
            else if (r < 92) cmd = CMD_STANDBY;
            else cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;

            // Tempos straddle the deadband around the shown value for two draws in five.
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                near = int'(sb.tempo_shown) + ($urandom_range(0, 1) ? 1 : -1)
                       * int'($urandom_range(0, int'(sb.deadband_q) + 3));
                if (near < 0) near = 0;
                tv = near[15:0];
            end
            else if (r < 70)
                tv = 16'($urandom_range(0, 999));
            else
                tv = 16'($urandom());
            send_event(cmd, tv, 8'($urandom()), 4'($urandom()));
        end
    endtask

    initial
    begin
        sb            = new();
        quiet         = 1'b0;
        events_sent   = 0;
        settings_used = 1;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_TICK;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: clamping, deadband, fixed screens, ignored events, idle entry.
        send_event(CMD_TICK, 16'd0, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'd0, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'hFFFF, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'd398, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'd397, 8'h00, 4'h0);
        send_event(CMD_STANDBY, 16'd0, 8'h00, 4'h0);
        send_event(CMD_SPARE_6, 16'hFFFF, 8'hFF, 4'hF);
        send_event(CMD_SPARE_7, 16'd0, 8'h00, 4'h0);
        send_event(CMD_MIDI, 16'd0, 8'hFF, 4'hF);
        send_event(CMD_CLOCK_START, 16'd0, 8'h00, 4'h0);
        send_event(CMD_IDLE_START, 16'd0, 8'h00, 4'h0);
        send_event(CMD_MIDI, 16'd0, 8'hA5, 4'h0);
        send_event(CMD_TEMPO, 16'd120, 8'h00, 4'h0);

        // Directed: fast animation, message hold and release, idle restart.
        configure(10'd20, 10'd400, 8'd2, 16'd1, 16'd3);
        repeat (8) send_event(CMD_TICK, 16'd0, 8'h00, 4'h0);
        send_event(CMD_MIDI, 16'd0, 8'h00, 4'hF);
        send_event(CMD_IDLE_START, 16'd0, 8'h00, 4'h0);
        send_event(CMD_TICK, 16'd0, 8'h00, 4'h0);
        send_event(CMD_CLOCK_START, 16'd0, 8'h00, 4'h0);

        // Directed: floor set above ceiling with no deadband.
        configure(10'd999, 10'd0, 8'd0, 16'd1, 16'd1);
        send_event(CMD_TEMPO, 16'd5, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'd2000, 8'h00, 4'h0);
        send_event(CMD_TEMPO, 16'd1, 8'h00, 4'h0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                configure(10'd0, 10'd999, 8'd255, 16'd65535, 16'd65535);
            else if (ph == 1)
                configure(10'd0, 10'd0, 8'd0, 16'd1, 16'd1);
            else
                configure(10'($urandom_range(0, 200)), 10'($urandom_range(150, 999)),
                          8'($urandom_range(0, 10)), 16'($urandom_range(1, 6)),
                          16'($urandom_range(1, 25)));
            quiet = (ph % 3 == 2);
            random_phase(120);
        end

        settle();
        repeat (6) @(posedge clk);
        $display("Sent %0d events under %0d register settings; %0d display beats checked.",
                 events_sent, settings_used, sb.displays_checked);
        $display("Mismatches found: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_displays.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
